>>> sv/mts_pkg.sv
// Package: shared constants, codes and controller command type for the max tracking stack.
package mts_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int PTR_W       = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int REQ_W    = 2;
    localparam int DATA_W   = 32;
    localparam int DEPTH_W  = 11;
    localparam int STATUS_W = 2;

    localparam logic [REQ_W-1:0] REQ_PUSH = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP  = 2'd1;

    localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POP_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_PUSH_FULL  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_READ_EMPTY = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic accept;
        logic exec;
    } ctrl_cmd_t;

endpackage

>>> sv/max_tracking_stack_unit.sv
// Top level: max tracking stack with controller and datapath.
// Each item is handled in order: start is taken while busy is low, the next cycle executes
// the request against the fill count and the top-of-stack maximum, and the result appears
// with done high in the cycle after that, while the block already takes the next item.
// The accept step covers the registered read of the running-maximum memory,
// which a pop needs to restore the maximum of the new top. The result is shown for one
// cycle only and cannot be held off, so the receiver must capture it when done is high.
module max_tracking_stack_unit
    import mts_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic        [REQ_W-1:0]    req_type,
    input  logic signed [DATA_W-1:0]   push_value,
    output logic                       done,
    output logic signed [DATA_W-1:0]   max_value,
    output logic        [DEPTH_W-1:0]  depth,
    output logic        [STATUS_W-1:0] status
);

    ctrl_cmd_t cmd;

    mts_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd)
    );

    mts_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .req_type   (req_type),
        .push_value (push_value),
        .done       (done),
        .max_value  (max_value),
        .depth      (depth),
        .status     (status)
    );

endmodule

>>> sv/mts_ctrl.sv
// Controller: sequences each item through accept and execute.
module mts_ctrl
    import mts_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output ctrl_cmd_t cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        busy       = 1'b0;
        cmd.accept = 1'b0;
        cmd.exec   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.accept = start;
            end
            S_EXEC:
            begin
                busy     = 1'b1;
                cmd.exec = 1'b1;
            end
            default:
            begin
                busy = 1'b0;
            end
        endcase
    end

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EXEC |=> state_reg == S_IDLE)
        else $error("execute state held longer than one cycle");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept |=> cmd.exec)
        else $error("accepted item not executed");

endmodule

>>> sv/mts_dp.sv
// Datapath: fill count, top-of-stack maximum, running maximum memory and result registers.
module mts_dp
    import mts_pkg::*;
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  ctrl_cmd_t                  cmd,
    input  logic        [REQ_W-1:0]    req_type,
    input  logic signed [DATA_W-1:0]   push_value,
    output logic                       done,
    output logic signed [DATA_W-1:0]   max_value,
    output logic        [DEPTH_W-1:0]  depth,
    output logic        [STATUS_W-1:0] status
);

    logic signed [DATA_W-1:0] max_mem [STACK_DEPTH];

    logic        [REQ_W-1:0]    req_reg;
    logic signed [DATA_W-1:0]   val_reg;
    logic        [CNT_W-1:0]    count_reg;
    logic        [CNT_W-1:0]    count_next;
    logic signed [DATA_W-1:0]   top_max_reg;
    logic signed [DATA_W-1:0]   top_max_next;
    logic signed [DATA_W-1:0]   rd_data_reg;
    logic                       done_reg;
    logic signed [DATA_W-1:0]   max_value_reg;
    logic signed [DATA_W-1:0]   max_value_next;
    logic        [DEPTH_W-1:0]  depth_reg;
    logic        [STATUS_W-1:0] status_reg;
    logic        [STATUS_W-1:0] status_next;
    logic                       wr_en;
    logic signed [DATA_W-1:0]   wr_max;
    logic        [PTR_W-1:0]    rd_addr;
    logic                       empty;
    logic                       full;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(STACK_DEPTH));
    assign rd_addr = PTR_W'(count_reg - CNT_W'(2));

    always_comb
    begin
        count_next   = count_reg;
        top_max_next = top_max_reg;
        status_next  = ST_OK;
        wr_en        = 1'b0;
        wr_max       = val_reg;
        case (req_reg)
            REQ_PUSH:
            begin
                if (full)
                begin
                    status_next = ST_PUSH_FULL;
                end
                else
                begin
                    if (!empty && (top_max_reg > val_reg))
                    begin
                        wr_max = top_max_reg;
                    end
                    wr_en        = 1'b1;
                    top_max_next = wr_max;
                    count_next   = count_reg + CNT_W'(1);
                end
            end
            REQ_POP:
            begin
                if (empty)
                begin
                    status_next = ST_POP_EMPTY;
                end
                else
                begin
                    count_next   = count_reg - CNT_W'(1);
                    top_max_next = rd_data_reg;
                end
            end
            default:
            begin
                if (empty)
                begin
                    status_next = ST_READ_EMPTY;
                end
            end
        endcase
        max_value_next = (count_next == '0) ? '0 : top_max_next;
    end

    always_ff @(posedge clk)
    begin
        rd_data_reg <= max_mem[rd_addr];
        if (cmd.exec && wr_en)
        begin
            max_mem[count_reg[PTR_W-1:0]] <= wr_max;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req_type;
            val_reg <= push_value;
        end
        if (cmd.exec)
        begin
            top_max_reg   <= top_max_next;
            max_value_reg <= max_value_next;
            depth_reg     <= DEPTH_W'(count_next);
            status_reg    <= status_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.exec;
            if (cmd.exec)
            begin
                count_reg <= count_next;
            end
        end
    end

    assign done      = done_reg;
    assign max_value = max_value_reg;
    assign depth     = depth_reg;
    assign status    = status_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(STACK_DEPTH))
        else $error("fill count beyond stack depth");

    a_depth_match: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> depth_reg == DEPTH_W'(count_reg))
        else $error("reported depth differs from fill count");

    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && count_reg == '0 |-> max_value_reg == '0)
        else $error("nonzero maximum reported on empty stack");

    a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg && status_reg == ST_PUSH_FULL |-> count_reg == CNT_W'(STACK_DEPTH))
        else $error("push dropped while stack not full");

endmodule
